FILE: hw/rtl/hsvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

    // Blend factor fraction bits (8..24) and the table's native precision.
    localparam int FRAC_BITS = 16;
    localparam int TAB_BITS  = 24;
    localparam int DROP      = TAB_BITS - FRAC_BITS;

    // Widths that follow from FRAC_BITS.
    localparam int FQ_W   = FRAC_BITS + 1;       // blend factor, 0..2^FB inclusive
    localparam int PROD_W = FRAC_BITS + 9;       // s * fq
    localparam int DIFF_W = FRAC_BITS + 8;       // 255*2^FB - s*fq
    localparam int BIG_W  = FRAC_BITS + 16;      // v * diff

    localparam logic [DIFF_W-1:0] FULL_SCALE = DIFF_W'(255) << FRAC_BITS;

    // x / 255 == (x * RECIP_255) >> 23 for every 16-bit x.
    localparam logic [16:0] RECIP_255 = 17'd32897;

    localparam logic [24:0] TAB_ONE = 25'd16777216;

    // Color-wheel sector, hue / 60 with out-of-range hue folded to sector 0.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector    sector;
        logic [7:0] sat;
        logic [7:0] val;
    } t_pix;

    // round(2^24 * (1 + cos(3k deg)) / 2), k = 0..30
    function automatic logic [23:0] blend_quarter(input logic [4:0] k);
        logic [23:0] e;
        case (k)
            5'd0:  e = 24'd16777215; // 2^24 itself handled by caller
            5'd1:  e = 24'd16765720;
            5'd2:  e = 24'd16731262;
            5'd3:  e = 24'd16673938;
            5'd4:  e = 24'd16593905;
            5'd5:  e = 24'd16491381;
            5'd6:  e = 24'd16366648;
            5'd7:  e = 24'd16220048;
            5'd8:  e = 24'd16051983;
            5'd9:  e = 24'd15862912;
            5'd10: e = 24'd15653356;
            5'd11: e = 24'd15423887;
            5'd12: e = 24'd15175134;
            5'd13: e = 24'd14907781;
            5'd14: e = 24'd14622559;
            5'd15: e = 24'd14320250;
            5'd16: e = 24'd14001682;
            5'd17: e = 24'd13667730;
            5'd18: e = 24'd13319308;
            5'd19: e = 24'd12957371;
            5'd20: e = 24'd12582912;
            5'd21: e = 24'd12196956;
            5'd22: e = 24'd11800562;
            5'd23: e = 24'd11394816;
            5'd24: e = 24'd10980830;
            5'd25: e = 24'd10559740;
            5'd26: e = 24'd10132698;
            5'd27: e = 24'd9700875;
            5'd28: e = 24'd9265456;
            5'd29: e = 24'd8827634;
            5'd30: e = 24'd8388608;
            default: e = 24'd8388608;
        endcase
        return e;
    endfunction

    // Full 25-bit table value, entry 0 being exactly 2^24.
    function automatic logic [24:0] blend_entry(input logic [4:0] k);
        logic [24:0] e;
        if (k == 5'd0) begin
            e = TAB_ONE;
        end else begin
            e = {1'b0, blend_quarter(k)};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hsvc_phase.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: sector and mirrored phase (0..60) of the hue.
module hsvc_phase
    import hsvc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire logic [8:0] i_hue,
    input  wire logic [7:0] i_sat,
    input  wire logic [7:0] i_val,
    output logic            o_valid,
    output t_pix            o_pix,
    output logic [5:0]      o_phase
);

    logic       r_valid;
    t_pix       r_pix;
    logic [5:0] r_phase;
    t_pix       n_pix;
    logic [5:0] n_phase;
    logic [8:0] hue_mod;
    logic [6:0] mod120;

    always_comb begin
        // hue mod 120 by compare and subtract, hue < 512
        if (i_hue >= 9'd480)      hue_mod = i_hue - 9'd480;
        else if (i_hue >= 9'd360) hue_mod = i_hue - 9'd360;
        else if (i_hue >= 9'd240) hue_mod = i_hue - 9'd240;
        else if (i_hue >= 9'd120) hue_mod = i_hue - 9'd120;
        else                      hue_mod = i_hue;
        mod120 = hue_mod[6:0];

        if (mod120 > 7'd60) n_phase = 6'(7'd120 - mod120);
        else                n_phase = mod120[5:0];

        if (i_hue < 9'd60)       n_pix.sector = SEC_RED_YEL;
        else if (i_hue < 9'd120) n_pix.sector = SEC_YEL_GRN;
        else if (i_hue < 9'd180) n_pix.sector = SEC_GRN_CYN;
        else if (i_hue < 9'd240) n_pix.sector = SEC_CYN_BLU;
        else if (i_hue < 9'd300) n_pix.sector = SEC_BLU_MAG;
        else if (i_hue < 9'd360) n_pix.sector = SEC_MAG_RED;
        else                     n_pix.sector = SEC_RED_YEL;
        n_pix.sat = i_sat;
        n_pix.val = i_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix   <= n_pix;
            r_phase <= n_phase;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_phase = r_phase;

endmodule

`default_nettype wire

FILE: hw/rtl/hsvc_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: cosine table lookup and rounding to FRAC_BITS.
module hsvc_blend
    import hsvc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_pix       i_pix,
    input  wire logic [5:0] i_phase,
    output logic            o_valid,
    output t_pix            o_pix,
    output logic [FQ_W-1:0] o_fq
);

    logic            r_valid;
    t_pix            r_pix;
    logic [FQ_W-1:0] r_fq;
    logic [FQ_W-1:0] n_fq;
    logic [24:0]     f24;
    logic [25:0]     rnd;

    always_comb begin
        if (i_phase <= 6'd30) begin
            f24 = blend_entry(i_phase[4:0]);
        end else begin
            f24 = TAB_ONE - blend_entry(5'(6'd60 - i_phase));
        end
        // round half up to FRAC_BITS
        rnd  = ({f24, 1'b0} >> DROP) + 26'd1;
        n_fq = rnd[FQ_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
            r_fq  <= n_fq;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_fq    = r_fq;

endmodule

`default_nettype wire

FILE: hw/rtl/hsvc_arith.sv
`timescale 1ns / 1ps
`default_nettype none

// Stages 3..5: products and exact floor divisions by 255 and by 255 * 2^FB.
module hsvc_arith
    import hsvc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_pix            i_pix,
    input  wire logic [FQ_W-1:0] i_fq,
    output logic                 o_valid,
    output t_sector              o_sector,
    output logic [7:0]           o_full,
    output logic [7:0]           o_mval,
    output logic [7:0]           o_nval
);

    // stage 3
    logic              r3_valid;
    t_pix              r3_pix;
    logic [PROD_W-1:0] r3_prod;
    logic [15:0]       r3_mnum;
    // stage 4
    logic              r4_valid;
    t_pix              r4_pix;
    logic [BIG_W-1:0]  r4_big;
    logic [15:0]       r4_mnum;
    // stage 5
    logic              r5_valid;
    t_pix              r5_pix;
    logic [7:0]        r5_mval;
    logic [7:0]        r5_nval;

    logic [DIFF_W-1:0] diff;
    logic [15:0]       nq;
    logic [32:0]       n_nmul;
    logic [32:0]       n_mmul;

    always_comb begin
        diff   = FULL_SCALE - DIFF_W'(r3_prod);
        nq     = r4_big[FRAC_BITS +: 16];
        n_nmul = 33'(nq) * 33'(RECIP_255);
        n_mmul = 33'(r4_mnum) * 33'(RECIP_255);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pix  <= i_pix;
            r3_prod <= PROD_W'(i_pix.sat) * PROD_W'(i_fq);
            r3_mnum <= 16'(i_pix.val) * 16'(8'd255 - i_pix.sat);

            r4_pix  <= r3_pix;
            r4_big  <= BIG_W'(r3_pix.val) * BIG_W'(diff);
            r4_mnum <= r3_mnum;

            r5_pix  <= r4_pix;
            r5_nval <= n_nmul[30:23];
            r5_mval <= n_mmul[30:23];
        end
    end

    assign o_valid  = r5_valid;
    assign o_sector = r5_pix.sector;
    assign o_full   = r5_pix.val;
    assign o_mval   = r5_mval;
    assign o_nval   = r5_nval;

endmodule

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_cosine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Smoothed HSV to RGB converter. One pixel (hue in degrees 0..359, 8-bit
// saturation and brightness) goes in per beat and one 8-bit RGB pixel comes
// out per beat. The pipeline is six register stages deep (phase, blend, three
// arithmetic stages and the output register): the edge that takes a pixel
// loads the first stage, and a new pixel can be taken every cycle while the
// output is not stalled. The blend F = 0.5 + 0.5*cos(hue*pi/60) comes from
// a 31-entry quarter-wave table rounded to FRAC_BITS fraction bits. Each
// channel is floor(v*c), c being 1, 1 - s/255 or 1 - (s/255)*F by sector,
// computed exactly, so a full channel is exactly v and zero saturation gives
// grey. Hue 360..511 uses sector 0 while F continues the 120-degree cosine.
// Backpressure stalls the whole pipeline at once: o_ready is low only while a
// finished pixel sits at the output unaccepted.
module hsv_to_rgb_cosine_top
    import hsvc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [8:0] i_hue_degrees,
    input  wire logic [7:0] i_saturation,
    input  wire logic [7:0] i_brightness,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_red_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_blue_out
);

    // pipeline advance: free unless the output beat is held
    logic            en;

    logic            s1_valid;
    t_pix            s1_pix;
    logic [5:0]      s1_phase;
    logic            s2_valid;
    t_pix            s2_pix;
    logic [FQ_W-1:0] s2_fq;
    logic            s5_valid;
    t_sector         s5_sector;
    logic [7:0]      s5_full;
    logic [7:0]      s5_mval;
    logic [7:0]      s5_nval;

    // output stage
    logic            r_valid;
    logic [7:0]      r_red;
    logic [7:0]      r_green;
    logic [7:0]      r_blue;
    logic [7:0]      n_red;
    logic [7:0]      n_green;
    logic [7:0]      n_blue;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    hsvc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_hue   (i_hue_degrees),
        .i_sat   (i_saturation),
        .i_val   (i_brightness),
        .o_valid (s1_valid),
        .o_pix   (s1_pix),
        .o_phase (s1_phase)
    );

    hsvc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_pix   (s1_pix),
        .i_phase (s1_phase),
        .o_valid (s2_valid),
        .o_pix   (s2_pix),
        .o_fq    (s2_fq)
    );

    hsvc_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s2_valid),
        .i_pix    (s2_pix),
        .i_fq     (s2_fq),
        .o_valid  (s5_valid),
        .o_sector (s5_sector),
        .o_full   (s5_full),
        .o_mval   (s5_mval),
        .o_nval   (s5_nval)
    );

    // Channel routing per sector: full (1), m and n components.
    always_comb begin
        unique case (s5_sector)
            SEC_YEL_GRN: begin
                n_red = s5_nval; n_green = s5_full; n_blue = s5_mval;
            end
            SEC_GRN_CYN: begin
                n_red = s5_mval; n_green = s5_full; n_blue = s5_nval;
            end
            SEC_CYN_BLU: begin
                n_red = s5_mval; n_green = s5_nval; n_blue = s5_full;
            end
            SEC_BLU_MAG: begin
                n_red = s5_nval; n_green = s5_mval; n_blue = s5_full;
            end
            SEC_MAG_RED: begin
                n_red = s5_full; n_green = s5_mval; n_blue = s5_nval;
            end
            default: begin
                n_red = s5_full; n_green = s5_nval; n_blue = s5_mval;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid     = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

`default_nettype wire

FILE: hw/rtl/hsvc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hsvc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_red_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_blue_out
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    // a held output beat stalls the input side
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while output beat stalled");

    // with nothing waiting at the output, input is always taken
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with empty output stage");

    // a stalled beat keeps its pixel
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out)))
        else $error("stalled output beat changed");

endmodule

bind hsv_to_rgb_cosine_top hsvc_checker u_hsvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);

`default_nettype wire

FILE: bench/hsv_to_rgb_cosine_top_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_cosine_top_tb;
    import hsvc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000; // hard stop bound for a hung pipe
    localparam int DRAIN_CYCLES = 16;     // six-stage pipe, plus slack
    localparam int IDLE_PCT     = 26;     // chance per cycle that a side idles
    localparam int RANDOM_BEATS = 620;
    localparam int STEADY_BEATS = 250;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_ready;
    logic [8:0] i_hue_degrees   = '0;
    logic [7:0] i_saturation    = '0;
    logic [7:0] i_brightness    = '0;
    logic       o_valid;
    logic       i_ready         = 1'b0;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;

    // Predicted pixels, oldest first, in the order their beats went in.
    t_rgb rgb_pending[$];
    int   mismatches  = 0;
    int   cycle_count = 0;
    // Set during the burst phase: neither side idles.
    bit   no_stall    = 1'b0;

    hsv_to_rgb_cosine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_hue_degrees (i_hue_degrees),
        .i_saturation  (i_saturation),
        .i_brightness  (i_brightness),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the pipe hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Output backpressure: random stalls except during the burst phase.
    always @(posedge i_clk) begin
        i_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // Quarter-wave cosine table, 24 fraction bits: round(2^24 * (1 + cos(3k deg)) / 2).
    function automatic logic [24:0] cosine_blend_24(input logic [4:0] k);
        logic [24:0] e;
        case (k)
            5'd0:  e = 25'd16777216;
            5'd1:  e = 25'd16765720;
            5'd2:  e = 25'd16731262;
            5'd3:  e = 25'd16673938;
            5'd4:  e = 25'd16593905;
            5'd5:  e = 25'd16491381;
            5'd6:  e = 25'd16366648;
            5'd7:  e = 25'd16220048;
            5'd8:  e = 25'd16051983;
            5'd9:  e = 25'd15862912;
            5'd10: e = 25'd15653356;
            5'd11: e = 25'd15423887;
            5'd12: e = 25'd15175134;
            5'd13: e = 25'd14907781;
            5'd14: e = 25'd14622559;
            5'd15: e = 25'd14320250;
            5'd16: e = 25'd14001682;
            5'd17: e = 25'd13667730;
            5'd18: e = 25'd13319308;
            5'd19: e = 25'd12957371;
            5'd20: e = 25'd12582912;
            5'd21: e = 25'd12196956;
            5'd22: e = 25'd11800562;
            5'd23: e = 25'd11394816;
            5'd24: e = 25'd10980830;
            5'd25: e = 25'd10559740;
            5'd26: e = 25'd10132698;
            5'd27: e = 25'd9700875;
            5'd28: e = 25'd9265456;
            5'd29: e = 25'd8827634;
            default: e = 25'd8388608;
        endcase
        return e;
    endfunction

    // Expected RGB for one HSV pixel. All math in 64 bits, so the exact
    // floor(v * component) never overflows for any FRAC_BITS in range.
    function automatic t_rgb hsv_pixel_to_rgb(input logic [8:0] hue,
                                              input logic [7:0] sat,
                                              input logic [7:0] val);
        logic [6:0]  phase;
        logic [63:0] f24;
        logic [63:0] fq;
        logic [63:0] one;
        logic [63:0] m_chan;
        logic [63:0] n_chan;
        t_sector     sector;
        t_rgb        rgb;
        // Cosine has a 120 degree period and is symmetric about 60.
        phase = 7'(hue % 9'd120);
        if (phase > 7'd60) phase = 7'd120 - phase;
        if (phase <= 7'd30) begin
            f24 = 64'(cosine_blend_24(phase[4:0]));
        end else begin
            f24 = 64'd16777216 - 64'(cosine_blend_24(5'(7'd60 - phase)));
        end
        // Round half up from 24 to FRAC_BITS fraction bits.
        fq     = (((f24 << 1) >> (24 - FRAC_BITS)) + 64'd1) >> 1;
        one    = 64'd1 << FRAC_BITS;
        m_chan = (64'(val) * (64'd255 - 64'(sat))) / 64'd255;
        n_chan = (64'(val) * (64'd255 * one - 64'(sat) * fq)) / (64'd255 * one);
        // Hue 360 and up lands in the first sector.
        if (hue >= 9'd360) sector = SEC_RED_YEL;
        else               sector = t_sector'(hue / 9'd60);
        case (sector)
            SEC_YEL_GRN: rgb = '{n_chan[7:0], val,         m_chan[7:0]};
            SEC_GRN_CYN: rgb = '{m_chan[7:0], val,         n_chan[7:0]};
            SEC_CYN_BLU: rgb = '{m_chan[7:0], n_chan[7:0], val};
            SEC_BLU_MAG: rgb = '{n_chan[7:0], m_chan[7:0], val};
            SEC_MAG_RED: rgb = '{val,         m_chan[7:0], n_chan[7:0]};
            default:     rgb = '{val,         n_chan[7:0], m_chan[7:0]};
        endcase
        return rgb;
    endfunction

    // Scoreboard: predict on each input beat, compare on each output beat.
    // Both handshakes are sampled at the edge, before any driver update lands.
    always @(posedge i_clk) begin : scoreboard
        t_rgb want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rgb_pending.push_back(hsv_pixel_to_rgb(i_hue_degrees, i_saturation,
                                                       i_brightness));
            end
            if (o_valid && i_ready) begin
                if (rgb_pending.size() == 0) begin
                    $error("output beat with no pixel pending: r=%0d g=%0d b=%0d",
                           o_red_out, o_green_out, o_blue_out);
                    mismatches++;
                end else begin
                    want = rgb_pending.pop_front();
                    if (o_red_out !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, o_red_out);
                        mismatches++;
                    end
                    if (o_green_out !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, o_green_out);
                        mismatches++;
                    end
                    if (o_blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, o_blue_out);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Drive one pixel: optional idle cycles first, then hold valid until taken.
    // Called right after an edge, so valid gets a single update per step.
    task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_hue_degrees <= hue;
        i_saturation  <= sat;
        i_brightness  <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Saturation or brightness: extremes or near-extremes 24 percent of the time.
    function automatic logic [7:0] pick_level();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)       return 8'd0;
        else if (roll < 16) return 8'd255;
        else if (roll < 24) return 8'($urandom_range(1, 0) ? 1 : 254);
        return 8'($urandom_range(255));
    endfunction

    // Hue: mostly the nominal 0..359, some beyond it, some on sector edges.
    function automatic logic [8:0] pick_hue();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return 9'($urandom_range(511, 360));
        if (roll < 20) return 9'(60 * $urandom_range(5) + ($urandom_range(1) ? 59 : 0));
        return 9'($urandom_range(359));
    endfunction

    // Sector boundaries, table fold points and out-of-range hue at full
    // saturation, then grey, black and near-extreme levels.
    task automatic test_corners();
        int unsigned corner_hues [18] = '{0, 30, 31, 59, 60, 90, 119, 120, 179, 180,
                                          239, 240, 299, 300, 359, 360, 420, 511};
        foreach (corner_hues[i]) send_pixel(9'(corner_hues[i]), 8'd255, 8'd255);
        send_pixel(9'd200, 8'd0,   8'd200);   // zero saturation gives grey
        send_pixel(9'd100, 8'd0,   8'd255);
        send_pixel(9'd45,  8'd255, 8'd0);     // black
        send_pixel(9'd15,  8'd255, 8'd1);
        send_pixel(9'd333, 8'd1,   8'd255);
        send_pixel(9'd75,  8'd128, 8'd128);
    endtask

    task automatic test_random_pixels(input int beats);
        repeat (beats) send_pixel(pick_hue(), pick_level(), pick_level());
    endtask

    // One beat per cycle both ways, no idling on either side.
    task automatic test_back_to_back(input int beats);
        no_stall = 1'b1;
        repeat (beats) send_pixel(pick_hue(), pick_level(), pick_level());
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_random_pixels(RANDOM_BEATS);
        test_back_to_back(STEADY_BEATS);
        test_random_pixels(RANDOM_BEATS / 10);
        i_valid <= 1'b0;

        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hsvc_pkg.sv
hw/rtl/hsvc_phase.sv
hw/rtl/hsvc_blend.sv
hw/rtl/hsvc_arith.sv
hw/rtl/hsv_to_rgb_cosine_top.sv
hw/rtl/hsvc_checker.sv
bench/hsv_to_rgb_cosine_top_tb.sv
